/* design/mnt_pkg.sv */
// Package for the mnemonic/number tokenizer: sizes, codes and character tests.
`timescale 1ns / 1ps
package mnt_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int BYTE_DIGITS = 8;
   localparam int NUM_KW      = 3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_INSTR   = 3'd2,
      MODE_BINARY  = 3'd3,
      MODE_DECIMAL = 3'd4,
      MODE_ERROR   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_INSTR   = 2'd0,
      KIND_BYTE    = 2'd1,
      KIND_NUMBER  = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MN_ILOAD  = 2'd0,
      MN_DUP    = 2'd1,
      MN_BIPUSH = 2'd2
   } mnemonic_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;

   // keyword spelling, padded with NUL to eight characters
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{8'h49, 8'h4C, 8'h4F, 8'h41, 8'h44, CH_NUL, CH_NUL, CH_NUL},  // ILOAD
      '{8'h44, 8'h55, 8'h50, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}, // DUP
      '{8'h42, 8'h49, 8'h50, 8'h55, 8'h53, 8'h48, CH_NUL, CH_NUL}     // BIPUSH
   };
   localparam logic [7:0] KW_LEN [NUM_KW] = '{8'd5, 8'd3, 8'd6};

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= 8'h39;
   endfunction

   function automatic logic is_bit(input logic [7:0] c);
      return c == CH_ZERO || c == CH_ONE;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == CH_SPACE || c == CH_NL || c == CH_NUL;
   endfunction

endpackage

/* design/mnemonic_number_tokenizer.sv */
// Top level of the mnemonic/number tokenizer: scan state and result register.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------------
//   req      | in        | req_valid/req_ready | ch, finish
//   rsp      | out       | rsp_valid/rsp_ready | token_kind, mnemonic, number_value,
//            |           |                     | value_saturated, text_length
//
// One character item per cycle. The scan state updates in the cycle an item is
// taken; a token closed by that item shows on rsp the next cycle from the result
// register. The single result register sets the rate: req_ready is high whenever
// it is empty or is being drained, so a stalled rsp holds req only while a result
// waits. Synchronous active-high reset returns the scanner to idle and empties the
// result register; no clearing pass.
`timescale 1ns / 1ps
module mnemonic_number_tokenizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_ch,
   input  logic                  req_finish,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mnt_pkg::kind_type     rsp_token_kind,
   output mnt_pkg::mnemonic_type rsp_mnemonic,
   output logic [31:0]           rsp_number_value,
   output logic                  rsp_value_saturated,
   output logic [7:0]            rsp_text_length
);
   import mnt_pkg::*;

   // scan state
   mode_type               mode_ff,  mode_in;
   logic [NUM_KW-1:0]      cand_ff,  cand_in;
   mnemonic_type           match_ff, match_in;
   logic [7:0]             count_ff, count_in;
   logic [BYTE_DIGITS-1:0] bin_ff,   bin_in;
   logic [VALUE_BITS-1:0]  dec_ff,   dec_in;
   logic                   ovf_ff,   ovf_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               kind_ff,  kind_in;
   mnemonic_type           mn_ff,    mn_in;
   logic [31:0]            value_ff, value_in;
   logic                   sat_ff,   sat_in;
   logic [7:0]             len_ff,   len_in;

   logic                   accept;
   logic                   emit;

   // datapath helpers
   logic [7:0]             count_inc;
   logic [3:0]             digit;
   logic [VALUE_BITS+3:0]  dec_wide;
   logic                   dec_over;
   logic [VALUE_BITS-1:0]  dec_push;
   logic [BYTE_DIGITS:0]   bin_shift;
   logic [BYTE_DIGITS-1:0] bin_push;
   logic [NUM_KW-1:0]      cand_hit;
   logic [VALUE_BITS+31:0] dec_ext;
   logic [BYTE_DIGITS+31:0] bin_ext;

   // pending token as it would be reported now
   logic                   pend_valid;
   kind_type               pend_kind;
   mnemonic_type           pend_mn;
   logic [31:0]            pend_value;
   logic                   pend_sat;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
   assign digit     = req_ch[3:0];

   // acc*10 + d, saturating once the sum leaves VALUE_BITS
   assign dec_wide  = {1'b0, dec_ff, 3'b000} + {3'b000, dec_ff, 1'b0}
                    + {{VALUE_BITS{1'b0}}, digit};
   assign dec_over  = |dec_wide[VALUE_BITS+3:VALUE_BITS];
   assign dec_push  = dec_over ? {VALUE_BITS{1'b1}} : dec_wide[VALUE_BITS-1:0];

   assign bin_shift = {bin_ff, req_ch[0]};
   assign bin_push  = bin_shift[BYTE_DIGITS-1:0];

   assign dec_ext   = {32'd0, dec_ff};
   assign bin_ext   = {32'd0, bin_ff};

   // keyword candidates surviving this letter
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         cand_hit[k] = cand_ff[k] && (count_ff < KW_LEN[k])
                     && (KW_TEXT[k][count_ff[2:0]] == req_ch);
      end
   end

   always_comb begin
      pend_valid = 1'b0;
      pend_kind  = KIND_INVALID;
      pend_mn    = MN_ILOAD;
      pend_value = 32'd0;
      pend_sat   = 1'b0;
      unique case (mode_ff)
         MODE_INSTR: begin
            pend_valid = 1'b1;
            pend_kind  = KIND_INSTR;
            pend_mn    = match_ff;
         end
         MODE_BINARY: begin
            pend_valid = 1'b1;
            if (count_ff == 8'(BYTE_DIGITS)) begin
               pend_kind  = KIND_BYTE;
               pend_value = bin_ext[31:0];
            end else begin
               pend_kind  = KIND_NUMBER;
               pend_value = dec_ext[31:0];
               pend_sat   = ovf_ff;
            end
         end
         MODE_DECIMAL: begin
            pend_valid = 1'b1;
            pend_kind  = KIND_NUMBER;
            pend_value = dec_ext[31:0];
            pend_sat   = ovf_ff;
         end
         MODE_WORD, MODE_ERROR: begin
            pend_valid = 1'b1;  // invalid word, reported only at finish
         end
         default: pend_valid = 1'b0;
      endcase
   end

   // next scan state and token close
   always_comb begin
      logic clear;
      clear    = 1'b0;
      emit     = 1'b0;
      mode_in  = mode_ff;
      cand_in  = cand_ff;
      match_in = match_ff;
      count_in = count_ff;
      bin_in   = bin_ff;
      dec_in   = dec_ff;
      ovf_in   = ovf_ff;

      if (accept) begin
         if (req_finish) begin
            emit  = pend_valid;
            clear = 1'b1;
         end else begin
            unique case (mode_ff)
               MODE_IDLE, MODE_WORD: begin
                  if (is_letter(req_ch)) begin
                     mode_in  = MODE_WORD;
                     count_in = count_inc;
                     cand_in  = cand_hit;
                     for (int k = 0; k < NUM_KW; k++) begin
                        if (cand_hit[k] && KW_LEN[k] == count_inc) begin
                           mode_in  = MODE_INSTR;
                           match_in = mnemonic_type'(2'(k));
                        end
                     end
                  end else if (mode_ff == MODE_WORD) begin
                     mode_in  = MODE_ERROR;
                     count_in = count_inc;
                  end else if (is_bit(req_ch)) begin
                     mode_in  = MODE_BINARY;
                     count_in = count_inc;
                     bin_in   = bin_push;
                     dec_in   = dec_push;
                     ovf_in   = ovf_ff | dec_over;
                  end else if (is_digit(req_ch)) begin
                     mode_in  = MODE_DECIMAL;
                     count_in = count_inc;
                     dec_in   = dec_push;
                     ovf_in   = ovf_ff | dec_over;
                  end else if (!is_sep(req_ch)) begin
                     mode_in  = MODE_ERROR;
                     count_in = count_inc;
                  end
               end
               MODE_INSTR, MODE_DECIMAL, MODE_BINARY: begin
                  if (is_sep(req_ch)) begin
                     emit  = 1'b1;
                     clear = 1'b1;
                  end else if (mode_ff == MODE_BINARY && count_ff < 8'(BYTE_DIGITS)
                               && is_bit(req_ch)) begin
                     count_in = count_inc;
                     bin_in   = bin_push;
                     dec_in   = dec_push;
                     ovf_in   = ovf_ff | dec_over;
                  end else if (mode_ff != MODE_INSTR && is_digit(req_ch)) begin
                     // decimal run grows; a binary run turns decimal on a non-bit digit or once too long
                     mode_in  = MODE_DECIMAL;
                     count_in = count_inc;
                     dec_in   = dec_push;
                     ovf_in   = ovf_ff | dec_over;
                  end else begin
                     mode_in  = MODE_ERROR;
                     count_in = count_inc;
                  end
               end
               MODE_ERROR: mode_in = MODE_ERROR;  // locked until finish
               default:    mode_in = MODE_IDLE;
            endcase
         end

         if (clear) begin
            mode_in  = MODE_IDLE;
            cand_in  = '1;
            match_in = MN_ILOAD;
            count_in = 8'd0;
            bin_in   = '0;
            dec_in   = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cand_ff  <= '1;
         match_ff <= MN_ILOAD;
         count_ff <= 8'd0;
         bin_ff   <= '0;
         dec_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         cand_ff  <= cand_in;
         match_ff <= match_in;
         count_ff <= count_in;
         bin_ff   <= bin_in;
         dec_ff   <= dec_in;
         ovf_ff   <= ovf_in;
      end
   end

   // result register: load on a closing item, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      mn_in        = mn_ff;
      value_in     = value_ff;
      sat_in       = sat_ff;
      len_in       = len_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = pend_kind;
         mn_in        = pend_mn;
         value_in     = pend_value;
         sat_in       = pend_sat;
         len_in       = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      mn_ff    <= mn_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
      len_ff   <= len_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_token_kind      = kind_ff;
   assign rsp_mnemonic        = mn_ff;
   assign rsp_number_value    = value_ff;
   assign rsp_value_saturated = sat_ff;
   assign rsp_text_length     = len_ff;

`ifndef SYNTH
   // a fresh result only follows an accepted item
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result appeared without an accepted item");

   // idle means a fully cleared scanner
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> (count_ff == 8'd0 && cand_ff == '1 && !ovf_ff
                                && dec_ff == '0 && bin_ff == '0))
      else $error("idle scanner holds stale token state");

   // a byte token is always exactly one full run of binary digits
   a_byte_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_BYTE |-> len_ff == 8'(BYTE_DIGITS))
      else $error("byte token with wrong length");

   // an instruction has the length of its keyword
   a_instr_len: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_INSTR |-> count_ff == KW_LEN[match_ff])
      else $error("instruction state with wrong length");
`endif

endmodule
